// ===== src/line_follower_pid_steering_unit_macros.svh =====
// assertion macros shared by the steering unit rtl
// no dependencies; included by files that carry concurrent checks
`ifndef LINE_FOLLOWER_PID_STEERING_UNIT_MACROS_SVH
`define LINE_FOLLOWER_PID_STEERING_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define LFPS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define LFPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lfps_pkg.sv =====
// types, constants and the sensor pattern table of the steering unit
// no dependencies; imported by every module of the unit
package lfps_pkg;

    localparam int unsigned GAIN_W   = 8;
    localparam int unsigned SPEED_W  = 8;
    localparam int unsigned SENSOR_W = 5;
    localparam int unsigned ERR_W    = 4;
    localparam int unsigned DIFF_W   = 5;
    localparam int unsigned INTEG_W  = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 2'd3;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = 16'sh7FFF;
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = 16'sh8000;
    localparam logic [SPEED_W-1:0]        SPEED_MAX = 8'd255;
    localparam logic signed [ERR_W-1:0]   ERR_LOW   = -4'sd4;
    localparam logic signed [ERR_W-1:0]   ERR_HIGH  = 4'sd4;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [SPEED_W-1:0] base_speed;
    } cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [DIFF_W-1:0]  diff;
        logic signed [INTEG_W-1:0] integ;
    } err_stage_t;

    typedef struct packed {
        logic                    hit;
        logic signed [ERR_W-1:0] err;
    } lookup_t;

    // sensor pattern to position error, bit0 is the leftmost sensor
    function automatic lookup_t lookup_error(input logic [SENSOR_W-1:0] pat);
        lookup_t res;
        res.hit = 1'b1;
        case (pat)
            5'h01:   res.err = -4'sd4;
            5'h03:   res.err = -4'sd3;
            5'h02:   res.err = -4'sd2;
            5'h06:   res.err = -4'sd1;
            5'h04:   res.err = 4'sd0;
            5'h0C:   res.err = 4'sd1;
            5'h08:   res.err = 4'sd2;
            5'h18:   res.err = 4'sd3;
            5'h10:   res.err = 4'sd4;
            default: begin
                res.hit = 1'b0;
                res.err = 4'sd0;
            end
        endcase
        return res;
    endfunction

endpackage

// ===== src/lfps_error_track.sv =====
// position error decode, held error and saturating integral state
// depends on lfps_pkg; feeds the decoded stage register to lfps_pid_calc
module lfps_error_track (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  logic [lfps_pkg::SENSOR_W-1:0]  sensor_bits,
    output lfps_pkg::err_stage_t           stage
);
    import lfps_pkg::*;

    // the previous step's error is always the held error
    logic signed [ERR_W-1:0]   held_error_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    err_stage_t                stage_reg;

    lookup_t                   lut;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [DIFF_W-1:0]  diff_next;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ_next;

    always_comb begin
        lut       = lookup_error(sensor_bits);
        err_next  = lut.hit ? lut.err : held_error_reg;
        diff_next = DIFF_W'(err_next) - DIFF_W'(held_error_reg);
        integ_sum = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(err_next);
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            integ_next = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        end else begin
            integ_next = integ_sum[INTEG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_error_reg <= '0;
            integ_reg      <= '0;
        end else if (load) begin
            held_error_reg <= err_next;
            integ_reg      <= integ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            stage_reg.err   <= err_next;
            stage_reg.diff  <= diff_next;
            stage_reg.integ <= integ_next;
        end
    end

    assign stage = stage_reg;

endmodule

// ===== src/lfps_pid_calc.sv =====
// pid sum and motor speed clamp, purely combinational
// depends on lfps_pkg; driven by the lfps_error_track stage register
module lfps_pid_calc (
    input  lfps_pkg::err_stage_t          stage,
    input  lfps_pkg::cfg_t                cfg,
    output logic [lfps_pkg::SPEED_W-1:0]  left_speed,
    output logic [lfps_pkg::SPEED_W-1:0]  right_speed
);
    import lfps_pkg::*;

    localparam int unsigned GS_W   = GAIN_W + 1;
    localparam int unsigned PP_W   = GS_W + ERR_W;
    localparam int unsigned PI_W   = GS_W + INTEG_W;
    localparam int unsigned PD_W   = GS_W + DIFF_W;
    localparam int unsigned SUM_W  = PI_W + 2;

    logic signed [GS_W-1:0]  gp_s;
    logic signed [GS_W-1:0]  gi_s;
    logic signed [GS_W-1:0]  gd_s;
    logic signed [PP_W-1:0]  prod_p;
    logic signed [PI_W-1:0]  prod_i;
    logic signed [PD_W-1:0]  prod_d;
    logic signed [SUM_W-1:0] pid;
    logic signed [SUM_W-1:0] base_s;
    logic signed [SUM_W-1:0] left_raw;
    logic signed [SUM_W-1:0] right_raw;

    function automatic logic [SPEED_W-1:0] clamp_speed(input logic signed [SUM_W-1:0] v);
        logic [SPEED_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > SUM_W'($signed({1'b0, SPEED_MAX}))) begin
            res = SPEED_MAX;
        end else begin
            res = v[SPEED_W-1:0];
        end
        return res;
    endfunction

    always_comb begin
        gp_s      = $signed({1'b0, cfg.gain_p});
        gi_s      = $signed({1'b0, cfg.gain_i});
        gd_s      = $signed({1'b0, cfg.gain_d});
        prod_p    = PP_W'(gp_s) * PP_W'(stage.err);
        prod_i    = PI_W'(gi_s) * PI_W'(stage.integ);
        prod_d    = PD_W'(gd_s) * PD_W'(stage.diff);
        pid       = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
        base_s    = $signed(SUM_W'(cfg.base_speed));
        left_raw  = base_s - pid;
        right_raw = base_s + pid;
        left_speed  = clamp_speed(left_raw);
        right_speed = clamp_speed(right_raw);
    end

endmodule

// ===== src/line_follower_pid_steering_unit.sv =====
// PID steering for a line follower: one 5-bit sensor sample in, one pair of
// motor speeds and the position error out. A sample is taken every cycle the
// input is ready; the decode/integral register loads at the transfer edge and
// the result register behind the pid and clamp logic loads when the stage
// advances into a free result register. Sustained rate is one sample per cycle
// while results are taken. Gains and base speed are written through the cfg
// port, by the user only while idle; the block itself does not enforce it.
// depends on lfps_pkg, lfps_error_track, lfps_pid_calc and the macros header
module line_follower_pid_steering_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lfps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lfps_pkg::GAIN_W-1:0]       cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [4:0] sensor_bits
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata    // [7:0] left_speed,
                                                         // [15:8] right_speed,
                                                         // [19:16] position_error
);
    import lfps_pkg::*;
`include "line_follower_pid_steering_unit_macros.svh"

    cfg_t                    cfg_reg;
    logic                    stg_valid_reg;
    logic                    stg_valid_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [SPEED_W-1:0]      left_reg;
    logic [SPEED_W-1:0]      right_reg;
    logic signed [ERR_W-1:0] err_reg;

    logic                    out_ready;
    logic                    stg_adv;
    logic                    s_xfer;
    err_stage_t              stage;
    logic [SPEED_W-1:0]      left_speed;
    logic [SPEED_W-1:0]      right_speed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GAIN_P:     cfg_reg.gain_p     <= cfg_wdata;
                REG_GAIN_I:     cfg_reg.gain_i     <= cfg_wdata;
                REG_GAIN_D:     cfg_reg.gain_d     <= cfg_wdata;
                REG_BASE_SPEED: cfg_reg.base_speed <= cfg_wdata;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    assign out_ready = !out_valid_reg || m_tready;
    assign stg_adv   = stg_valid_reg && out_ready;
    assign s_tready  = !stg_valid_reg || out_ready;
    assign s_xfer    = s_tvalid && s_tready;

    always_comb begin
        stg_valid_next = stg_valid_reg;
        if (s_xfer) begin
            stg_valid_next = 1'b1;
        end else if (stg_adv) begin
            stg_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (stg_adv) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            stg_valid_reg <= stg_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    lfps_error_track u_error_track (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (s_xfer),
        .sensor_bits (s_tdata[SENSOR_W-1:0]),
        .stage       (stage)
    );

    lfps_pid_calc u_pid_calc (
        .stage       (stage),
        .cfg         (cfg_reg),
        .left_speed  (left_speed),
        .right_speed (right_speed)
    );

    always_ff @(posedge aclk) begin
        if (stg_adv) begin
            left_reg  <= left_speed;
            right_reg <= right_speed;
            err_reg   <= stage.err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, err_reg, right_reg, left_reg};

    `LFPS_ASSERT_NEXT(a_xfer_fills_stage, aclk, aresetn,
        s_xfer, stg_valid_reg, "accepted sample did not reach the decode stage")
    `LFPS_ASSERT_NEXT(a_stage_reaches_out, aclk, aresetn,
        stg_adv, out_valid_reg, "decoded sample did not reach the result register")
    `LFPS_ASSERT_NEXT(a_drain_empties, aclk, aresetn,
        out_valid_reg && m_tready && !stg_valid_reg, !out_valid_reg,
        "result register kept a transfer that was already taken")
    `LFPS_ASSERT_NOW(a_err_range, aclk, aresetn,
        out_valid_reg, (err_reg >= ERR_LOW) && (err_reg <= ERR_HIGH),
        "position error out of range")

endmodule

// ===== bench/tb.sv =====
// self-checking bench for line_follower_pid_steering_unit: sensor samples in,
// motor speeds and position error out, compared against a pid predictor
// depends on lfps_pkg and the steering unit rtl
module tb;
    import lfps_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [ERR_W-1:0]   pos_err;
        logic [SPEED_W-1:0] right;
        logic [SPEED_W-1:0] left;
    } steer_res_t;

    localparam logic [SENSOR_W-1:0] LINE_PATTERNS [9] = '{
        5'h01, 5'h03, 5'h02, 5'h06, 5'h04, 5'h0C, 5'h08, 5'h18, 5'h10
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [GAIN_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [23:0]          m_tdata;

    line_follower_pid_steering_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 aclk = ~aclk;

    // predictor state and register copies
    logic [GAIN_W-1:0]  mdl_gain_p = '0;
    logic [GAIN_W-1:0]  mdl_gain_i = '0;
    logic [GAIN_W-1:0]  mdl_gain_d = '0;
    logic [SPEED_W-1:0] mdl_base = '0;
    int                 held_err = 0;
    int                 prev_err = 0;
    int                 integ_acc = 0;

    logic [SENSOR_W-1:0] sample_q[$];
    steer_res_t          steer_q[$];

    bit quiet = 1'b0;
    int s_idle = 0;
    int m_idle = 0;
    int errors = 0;
    int samples_sent = 0;
    int results_seen = 0;
    int settings_used = 0;
    int held_count = 0;
    int integ_top = 0;
    int integ_bottom = 0;
    int cycles = 0;

    logic                drv_valid;
    logic [7:0]          drv_data;
    steer_res_t          mon_exp;
    steer_res_t          mon_act;

    function automatic logic [SPEED_W-1:0] speed_clamp(input longint v);
        if (v < 0)
            return '0;
        if (v > longint'(SPEED_MAX))
            return SPEED_MAX;
        return v[SPEED_W-1:0];
    endfunction

    function automatic steer_res_t predict_steering(input logic [SENSOR_W-1:0] pat);
        steer_res_t r;
        int         e;
        longint     pid;
        case (pat)
            5'h01: held_err = -4;
            5'h03: held_err = -3;
            5'h02: held_err = -2;
            5'h06: held_err = -1;
            5'h04: held_err = 0;
            5'h0C: held_err = 1;
            5'h08: held_err = 2;
            5'h18: held_err = 3;
            5'h10: held_err = 4;
            default: held_count++;
        endcase
        e = held_err;
        integ_acc = integ_acc + e;
        if (integ_acc > 32767) begin
            integ_acc = 32767;
            integ_top++;
        end
        if (integ_acc < -32768) begin
            integ_acc = -32768;
            integ_bottom++;
        end
        pid = longint'(mdl_gain_p) * e + longint'(mdl_gain_i) * integ_acc
            + longint'(mdl_gain_d) * (e - prev_err);
        prev_err = e;
        r.left    = speed_clamp(longint'(mdl_base) - pid);
        r.right   = speed_clamp(longint'(mdl_base) + pid);
        r.pos_err = e[ERR_W-1:0];
        return r;
    endfunction

    function automatic logic [SENSOR_W-1:0] random_sample();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            return LINE_PATTERNS[$urandom_range(0, 8)];
        if (pick < 85)
            return '0;
        return SENSOR_W'($urandom_range(0, 31));
    endfunction

    // input driver: one transfer per accepted sample, random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_idle = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                steer_q.push_back(predict_steering(s_tdata[SENSOR_W-1:0]));
                samples_sent++;
            end
            drv_valid = s_tvalid && !s_tready;
            drv_data  = s_tdata;
            if (!drv_valid) begin
                if (s_idle > 0) begin
                    s_idle--;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    s_idle = $urandom_range(1, 19) - 1;
                end else if (sample_q.size() > 0) begin
                    drv_valid = 1'b1;
                    drv_data  = {3'b000, sample_q.pop_front()};
                end
            end
            s_tvalid <= drv_valid;
            s_tdata  <= drv_data;
        end
    end

    // result monitor and back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_idle = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                mon_act = {m_tdata[19:16], m_tdata[15:8], m_tdata[7:0]};
                if (steer_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $realtime, m_tdata);
                    errors++;
                end else begin
                    mon_exp = steer_q.pop_front();
                    if (mon_act.left !== mon_exp.left) begin
                        $display("%0t: left_speed expected %0d actual %0d",
                                 $realtime, mon_exp.left, mon_act.left);
                        errors++;
                    end
                    if (mon_act.right !== mon_exp.right) begin
                        $display("%0t: right_speed expected %0d actual %0d",
                                 $realtime, mon_exp.right, mon_act.right);
                        errors++;
                    end
                    if (mon_act.pos_err !== mon_exp.pos_err) begin
                        $display("%0t: position_error expected %0d actual %0d",
                                 $realtime, $signed(mon_exp.pos_err),
                                 $signed(mon_act.pos_err));
                        errors++;
                    end
                end
            end
            if (m_idle > 0) begin
                m_idle--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_idle = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_GAIN_P:     mdl_gain_p = val;
            REG_GAIN_I:     mdl_gain_i = val;
            REG_GAIN_D:     mdl_gain_d = val;
            REG_BASE_SPEED: mdl_base = val;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [7:0] p, input logic [7:0] i,
                                 input logic [7:0] d, input logic [7:0] b);
        write_reg(REG_GAIN_P, p);
        write_reg(REG_GAIN_I, i);
        write_reg(REG_GAIN_D, d);
        write_reg(REG_BASE_SPEED, b);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        settings_used++;
    endtask

    // checked at the falling edge so driver and monitor updates have settled
    task automatic drain();
        @(negedge aclk);
        while (sample_q.size() != 0 || s_tvalid || steer_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic random_batch(input int n);
        repeat (n) sample_q.push_back(random_sample());
        drain();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all nine line positions, lost line, odd patterns, field extremes
        apply_setting(8'd6, 8'd1, 8'd9, 8'd120);
        foreach (LINE_PATTERNS[k])
            sample_q.push_back(LINE_PATTERNS[k]);
        foreach (LINE_PATTERNS[k])
            sample_q.push_back(LINE_PATTERNS[8 - k]);
        sample_q.push_back(5'h00);
        sample_q.push_back(5'h1F);
        sample_q.push_back(5'h05);
        sample_q.push_back(5'h11);
        sample_q.push_back(5'h00);
        sample_q.push_back(5'h01);
        drain();

        apply_setting(8'd0, 8'd0, 8'd0, 8'd0);
        random_batch(50);
        apply_setting(8'd255, 8'd255, 8'd255, 8'd255);
        random_batch(50);
        apply_setting(8'd255, 8'd0, 8'd0, 8'd128);
        random_batch(50);
        apply_setting(8'd0, 8'd0, 8'd255, 8'd128);
        random_batch(50);
        repeat (3) begin
            apply_setting(8'($urandom_range(0, 15)), 8'($urandom_range(0, 1)),
                          8'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
            random_batch(50);
        end
        apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        random_batch(50);

        // no idling on either side from here on
        quiet = 1'b1;
        apply_setting(8'd20, 8'd0, 8'd7, 8'd130);
        random_batch(50);

        $display("covered %0d samples over %0d gain settings, %0d results compared",
                 samples_sent, settings_used, results_seen);
        $display("integral clipped high %0d and low %0d times, %0d samples held the error",
                 integ_top, integ_bottom, held_count);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
